// ===== rtl/gbsc_pkg.sv =====
`timescale 1ns / 1ps

package gbsc_pkg;

	// field widths
	localparam int unsigned READ_W  = 12;
	localparam int unsigned SUM_W   = 16;
	localparam int unsigned ROUND_W = 10;
	localparam int unsigned TOL_W   = 12;

	// three-read average: x / 3 == (x * RECIP3) >> RECIP3_SHIFT for x below 2**16
	localparam int unsigned RAW3_W       = READ_W + 2;
	localparam int unsigned RECIP3_W     = 16;
	localparam int unsigned RECIP3_SHIFT = 17;
	localparam logic [RECIP3_W-1:0] RECIP3 = 16'd43691;

	// configuration register reset values
	localparam logic [TOL_W-1:0]   TOL_RESET  = 12'd2;
	localparam logic [ROUND_W-1:0] MAXR_RESET = 10'd500;

	// register index decoded from the address
	localparam logic REG_TOLERANCE  = 1'b0;
	localparam logic REG_MAX_ROUNDS = 1'b1;

	// item actions
	localparam logic ACT_SAMPLE  = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	typedef struct packed {
		logic              action;
		logic [READ_W-1:0] nh3_read_a;
		logic [READ_W-1:0] nh3_read_b;
		logic [READ_W-1:0] nh3_read_c;
		logic [READ_W-1:0] co_read_a;
		logic [READ_W-1:0] co_read_b;
		logic [READ_W-1:0] co_read_c;
		logic [READ_W-1:0] no2_read_a;
		logic [READ_W-1:0] no2_read_b;
		logic [READ_W-1:0] no2_read_c;
	} sample_t;

	typedef struct packed {
		logic              done_res;
		logic              failed;
		logic [READ_W-1:0] nh3_baseline;
		logic [READ_W-1:0] co_baseline;
		logic [READ_W-1:0] no2_baseline;
		logic              nh3_stable;
		logic              co_stable;
		logic              no2_stable;
	} result_t;

	// controls from the round sequencer to one channel
	typedef struct packed {
		logic clear;
		logic update;
	} chan_ctl_t;

endpackage

// ===== rtl/gas_baseline_stability_calibrator.sv =====
`timescale 1ns / 1ps

// Baseline calibrator for three gas channels. Each sample item carries three raw
// 12-bit reads per channel; the block averages them, keeps a WINDOW-deep moving
// window per channel and reports the truncated window means as baselines plus a
// per-channel stable flag (|mean - average| < tolerance). Calibration finishes
// when all three channels are stable or max_rounds rounds have been taken, the
// latter flagged as failed; later sample items change nothing until a restart item.
// One item is accepted every cycle while the result side keeps up; each item
// passes the input register, the averaging stage into the average register and
// the window update into the result register, the window and round state being
// updated in the last stage so consecutive items see each other's effect.
// Registers: tolerance at 0x0 (reset 2), max_rounds at 0x4 (reset 500).
module gas_baseline_stability_calibrator #(
	parameter int unsigned WINDOW = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// sample channel
	input  logic                   sample_valid,
	output logic                   sample_ready,
	input  gbsc_pkg::sample_t      sample,
	// result channel
	output logic                   result_valid,
	input  logic                   result_ready,
	output gbsc_pkg::result_t      result,
	// configuration port
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import gbsc_pkg::*;

	localparam int unsigned SLOT_W = $clog2(WINDOW);

	logic [TOL_W-1:0]   tolerance_q;
	logic [ROUND_W-1:0] max_rounds_q;

	logic               valid_s1;
	sample_t            sample_s1;
	logic               valid_s2;
	logic               action_s2;
	logic [READ_W-1:0]  cur_nh3_s2, cur_co_s2, cur_no2_s2;
	logic [READ_W-1:0]  cur_nh3, cur_co, cur_no2;

	logic [SLOT_W-1:0]  slot_q;
	logic [ROUND_W-1:0] round_q;
	logic               finished_q;
	logic               fail_q;

	logic               result_valid_q;
	result_t            result_q;

	logic               advance;
	logic               round_go;
	chan_ctl_t          ctl;
	logic [ROUND_W-1:0] round_next;
	logic               fin_next;
	logic               fail_next;
	logic [READ_W-1:0]  mean_nh3, mean_co, mean_no2;
	logic               stab_nh3, stab_co, stab_no2;
	result_t            result_next;

	// configuration writes and reads
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q  <= TOL_RESET;
			max_rounds_q <= MAXR_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_TOLERANCE:  tolerance_q  <= pwdata[TOL_W-1:0];
				REG_MAX_ROUNDS: max_rounds_q <= pwdata[ROUND_W-1:0];
				default:        ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TOLERANCE:  prdata = 32'(tolerance_q);
			REG_MAX_ROUNDS: prdata = 32'(max_rounds_q);
			default:        prdata = '0;
		endcase
	end

	// the whole pipe moves when the result register is free or being taken
	assign advance      = !result_valid_q || result_ready;
	assign sample_ready = advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	// three-read averages per channel
	gbsc_avg u_avg_nh3 (
		.read_a (sample_s1.nh3_read_a),
		.read_b (sample_s1.nh3_read_b),
		.read_c (sample_s1.nh3_read_c),
		.avg    (cur_nh3)
	);

	gbsc_avg u_avg_co (
		.read_a (sample_s1.co_read_a),
		.read_b (sample_s1.co_read_b),
		.read_c (sample_s1.co_read_c),
		.avg    (cur_co)
	);

	gbsc_avg u_avg_no2 (
		.read_a (sample_s1.no2_read_a),
		.read_b (sample_s1.no2_read_b),
		.read_c (sample_s1.no2_read_c),
		.avg    (cur_no2)
	);

	// average register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			action_s2  <= sample_s1.action;
			cur_nh3_s2 <= cur_nh3;
			cur_co_s2  <= cur_co;
			cur_no2_s2 <= cur_no2;
		end
	end

	// round control: restart clears, a sample round updates while not finished
	assign round_go   = advance && valid_s2;
	assign ctl.clear  = round_go && (action_s2 == ACT_RESTART);
	assign ctl.update = round_go && (action_s2 == ACT_SAMPLE) && !finished_q;

	gbsc_chan #(.WINDOW(WINDOW)) u_chan_nh3 (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.slot      (slot_q),
		.cur       (cur_nh3_s2),
		.tolerance (tolerance_q),
		.mean      (mean_nh3),
		.stable    (stab_nh3)
	);

	gbsc_chan #(.WINDOW(WINDOW)) u_chan_co (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.slot      (slot_q),
		.cur       (cur_co_s2),
		.tolerance (tolerance_q),
		.mean      (mean_co),
		.stable    (stab_co)
	);

	gbsc_chan #(.WINDOW(WINDOW)) u_chan_no2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.slot      (slot_q),
		.cur       (cur_no2_s2),
		.tolerance (tolerance_q),
		.mean      (mean_no2),
		.stable    (stab_no2)
	);

	// finish decision for a taken round
	always_comb begin
		round_next = round_q + 1'b1;
		fin_next   = finished_q;
		fail_next  = fail_q;
		if (round_next >= max_rounds_q) begin
			fin_next  = 1'b1;
			fail_next = 1'b1;
		end else if (stab_nh3 && stab_co && stab_no2) begin
			fin_next = 1'b1;
		end
	end

	// result item
	always_comb begin
		result_next = '0;
		if (action_s2 == ACT_SAMPLE) begin
			result_next.nh3_baseline = mean_nh3;
			result_next.co_baseline  = mean_co;
			result_next.no2_baseline = mean_no2;
			if (finished_q) begin
				result_next.done_res = 1'b1;
				result_next.failed   = fail_q;
			end else begin
				result_next.done_res   = fin_next;
				result_next.failed     = fail_next;
				result_next.nh3_stable = stab_nh3;
				result_next.co_stable  = stab_co;
				result_next.no2_stable = stab_no2;
			end
		end
	end

	// calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			round_q    <= '0;
			finished_q <= 1'b0;
			fail_q     <= 1'b0;
		end else if (ctl.clear) begin
			slot_q     <= '0;
			round_q    <= '0;
			finished_q <= 1'b0;
			fail_q     <= 1'b0;
		end else if (ctl.update) begin
			if (slot_q == SLOT_W'(WINDOW - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
			round_q    <= round_next;
			finished_q <= fin_next;
			fail_q     <= fail_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (round_go) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/gbsc_avg.sv =====
`timescale 1ns / 1ps

module gbsc_avg (
	input  logic [gbsc_pkg::READ_W-1:0] read_a,
	input  logic [gbsc_pkg::READ_W-1:0] read_b,
	input  logic [gbsc_pkg::READ_W-1:0] read_c,
	output logic [gbsc_pkg::READ_W-1:0] avg
);
	import gbsc_pkg::*;

	logic [RAW3_W-1:0]          raw_sum;
	logic [RAW3_W+RECIP3_W-1:0] prod;

	// sum of the three reads, then divide by three through the reciprocal
	always_comb begin
		raw_sum = RAW3_W'(read_a) + RAW3_W'(read_b) + RAW3_W'(read_c);
		prod    = (RAW3_W+RECIP3_W)'(raw_sum) * (RAW3_W+RECIP3_W)'(RECIP3);
		avg     = prod[RECIP3_SHIFT +: READ_W];
	end

endmodule

// ===== rtl/gbsc_chan.sv =====
`timescale 1ns / 1ps

module gbsc_chan #(
	parameter int unsigned WINDOW = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gbsc_pkg::chan_ctl_t                 ctl,
	input  logic [$clog2(WINDOW)-1:0]           slot,
	input  logic [gbsc_pkg::READ_W-1:0]         cur,
	input  logic [gbsc_pkg::TOL_W-1:0]          tolerance,
	output logic [gbsc_pkg::READ_W-1:0]         mean,
	output logic                                stable
);
	import gbsc_pkg::*;

	// mean = sum / WINDOW == (sum * RECIP_W) >> RECIP_SHIFT for any 16-bit sum
	localparam int unsigned RECIP_SHIFT = SUM_W + 4;
	localparam int unsigned RECIP_BITS  = RECIP_SHIFT;
	localparam int unsigned RECIP_W     = ((2 ** RECIP_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int unsigned PROD_W      = SUM_W + RECIP_BITS;

	logic [READ_W-1:0] win_q [WINDOW];
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_next;
	logic [PROD_W-1:0] prod;
	logic [READ_W-1:0] diff;

	// running sum after this round, or held when the round is not taken
	always_comb begin
		if (ctl.update) begin
			sum_next = sum_q + SUM_W'(cur) - SUM_W'(win_q[slot]);
		end else begin
			sum_next = sum_q;
		end
	end

	// truncated window mean and distance to the current average
	always_comb begin
		prod = PROD_W'(sum_next) * PROD_W'(RECIP_BITS'(RECIP_W));
		mean = prod[RECIP_SHIFT +: READ_W];
		if (mean >= cur) begin
			diff = mean - cur;
		end else begin
			diff = cur - mean;
		end
		stable = (diff < tolerance);
	end

	// ring window and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			sum_q <= '0;
			for (int i = 0; i < WINDOW; i++) begin
				win_q[i] <= '0;
			end
		end else if (ctl.update) begin
			sum_q       <= sum_next;
			win_q[slot] <= cur;
		end
	end

endmodule

// ===== sim/baseline_checker.sv =====
`timescale 1ns / 1ps

module baseline_checker #(
	parameter int unsigned WINDOW = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_ready,
	input  gbsc_pkg::sample_t  sample,
	input  logic               result_valid,
	input  logic               result_ready,
	input  gbsc_pkg::result_t  result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending,
	output logic               calibrated,
	output int                 results_seen,
	output int                 settled_count,
	output int                 limit_count
);

	import gbsc_pkg::*;

	// shadow registers
	logic [TOL_W-1:0]   tol_reg;
	logic [ROUND_W-1:0] round_limit;

	// shadow calibration state
	logic [READ_W-1:0]  chan_win [3][WINDOW];
	logic [SUM_W-1:0]   win_sum [3];
	int unsigned        slot_next;
	logic [ROUND_W-1:0] rounds_taken;
	logic               cal_done;
	logic               cal_failed;

	// results still owed by the block, oldest first
	result_t            baselines_due [$];
	result_t            want;

	// restart: empty windows, no rounds taken
	function automatic void wipe_windows();
		for (int ch = 0; ch < 3; ch++) begin
			for (int i = 0; i < WINDOW; i++) chan_win[ch][i] = '0;
			win_sum[ch] = '0;
		end
		slot_next    = 0;
		rounds_taken = '0;
		cal_done     = 1'b0;
		cal_failed   = 1'b0;
	endfunction

	// one sample item through the calibration, returns the result it causes
	function automatic result_t settle_round(input sample_t s);
		result_t     r;
		int unsigned rd [3][3];
		int unsigned cur;
		int unsigned mean;
		int unsigned diff;
		int unsigned slot;
		logic [2:0]  steady;
		r      = '0;
		steady = '0;
		if (s.action == ACT_RESTART) begin
			wipe_windows();
			return r;
		end
		if (!cal_done) begin
			rd[0][0] = 32'(s.nh3_read_a);
			rd[0][1] = 32'(s.nh3_read_b);
			rd[0][2] = 32'(s.nh3_read_c);
			rd[1][0] = 32'(s.co_read_a);
			rd[1][1] = 32'(s.co_read_b);
			rd[1][2] = 32'(s.co_read_c);
			rd[2][0] = 32'(s.no2_read_a);
			rd[2][1] = 32'(s.no2_read_b);
			rd[2][2] = 32'(s.no2_read_c);
			slot = (slot_next >= WINDOW) ? 0 : slot_next;
			for (int ch = 0; ch < 3; ch++) begin
				cur = (rd[ch][0] + rd[ch][1] + rd[ch][2]) / 3;
				win_sum[ch] = SUM_W'(win_sum[ch] + cur - chan_win[ch][slot]);
				chan_win[ch][slot] = READ_W'(cur);
				mean = (win_sum[ch] / WINDOW) & 32'hFFF;
				diff = (mean >= cur) ? mean - cur : cur - mean;
				steady[ch] = (diff < tol_reg);
			end
			slot_next    = (slot + 1) % WINDOW;
			rounds_taken = rounds_taken + 1'b1;
			// the round limit wins over stability
			if (rounds_taken >= round_limit) begin
				cal_done   = 1'b1;
				cal_failed = 1'b1;
				limit_count++;
			end else if (&steady) begin
				cal_done = 1'b1;
				settled_count++;
			end
		end
		r.done_res     = cal_done;
		r.failed       = cal_failed;
		r.nh3_baseline = READ_W'(win_sum[0] / WINDOW);
		r.co_baseline  = READ_W'(win_sum[1] / WINDOW);
		r.no2_baseline = READ_W'(win_sum[2] / WINDOW);
		r.nh3_stable   = steady[0];
		r.co_stable    = steady[1];
		r.no2_stable   = steady[2];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [11:0] exp_v,
			input logic [11:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	// watch the register port and both item channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_reg       = TOL_RESET;
			round_limit   = MAXR_RESET;
			wipe_windows();
			baselines_due.delete();
			fail_count    = 0;
			results_seen  = 0;
			settled_count = 0;
			limit_count   = 0;
			pending      <= 0;
			calibrated   <= 1'b0;
		end else begin
			// register writes and read-back
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_TOLERANCE) tol_reg = pwdata[TOL_W-1:0];
					else round_limit = pwdata[ROUND_W-1:0];
				end else if (paddr[2] == REG_TOLERANCE) begin
					check_field("prdata tolerance", 12'(tol_reg), prdata[11:0]);
					check_field("prdata tolerance upper", 12'd0, prdata[23:12]);
				end else begin
					check_field("prdata max_rounds", 12'(round_limit), prdata[11:0]);
					check_field("prdata max_rounds upper", 12'd0, prdata[23:12]);
				end
			end
			// result item against the oldest expectation
			if (result_valid && result_ready) begin
				results_seen++;
				if (baselines_due.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					want = baselines_due.pop_front();
					check_field("done_res", 12'(want.done_res), 12'(result.done_res));
					check_field("failed", 12'(want.failed), 12'(result.failed));
					check_field("nh3_baseline", want.nh3_baseline, result.nh3_baseline);
					check_field("co_baseline", want.co_baseline, result.co_baseline);
					check_field("no2_baseline", want.no2_baseline, result.no2_baseline);
					check_field("nh3_stable", 12'(want.nh3_stable), 12'(result.nh3_stable));
					check_field("co_stable", 12'(want.co_stable), 12'(result.co_stable));
					check_field("no2_stable", 12'(want.no2_stable), 12'(result.no2_stable));
				end
			end
			// sample item accepted
			if (sample_valid && sample_ready) baselines_due.push_back(settle_round(sample));
			pending    <= baselines_due.size();
			calibrated <= cal_done;
		end
	end

endmodule

// ===== sim/tb_gas_baseline_stability_calibrator.sv =====
`timescale 1ns / 1ps

module tb_gas_baseline_stability_calibrator;

	import gbsc_pkg::*;

	localparam int unsigned WINDOW       = 10;
	localparam int          RANDOM_ITEMS = 150;
	localparam logic [2:0]  TOL_ADDR     = {REG_TOLERANCE, 2'b00};
	localparam logic [2:0]  MAXR_ADDR    = {REG_MAX_ROUNDS, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        sample_valid;
	logic        sample_ready;
	sample_t     sample;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	logic        calibrated;
	int          results_seen;
	int          settled_count;
	int          limit_count;

	logic        calm;
	int          items_sent;
	int          restarts_sent;
	int          settings;

	gas_baseline_stability_calibrator #(.WINDOW(WINDOW)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	baseline_checker #(.WINDOW(WINDOW)) watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_valid  (sample_valid),
		.sample_ready  (sample_ready),
		.sample        (sample),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.fail_count    (fail_count),
		.pending       (pending),
		.calibrated    (calibrated),
		.results_seen  (results_seen),
		.settled_count (settled_count),
		.limit_count   (limit_count)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side stalls now and then, never during the calm stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= calm || ($urandom_range(99) >= 8);
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// read near a base value, clamped to the adc range
	function automatic logic [READ_W-1:0] jittered(input logic [READ_W-1:0] base,
			input int unsigned jit);
		int v;
		v = int'(base) + int'($urandom_range(2 * jit, 0)) - int'(jit);
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return READ_W'(v);
	endfunction

	function automatic sample_t steady_round(input logic [READ_W-1:0] nh3,
			input logic [READ_W-1:0] co, input logic [READ_W-1:0] no2,
			input int unsigned jit);
		sample_t s;
		s.action     = ACT_SAMPLE;
		s.nh3_read_a = jittered(nh3, jit);
		s.nh3_read_b = jittered(nh3, jit);
		s.nh3_read_c = jittered(nh3, jit);
		s.co_read_a  = jittered(co, jit);
		s.co_read_b  = jittered(co, jit);
		s.co_read_c  = jittered(co, jit);
		s.no2_read_a = jittered(no2, jit);
		s.no2_read_b = jittered(no2, jit);
		s.no2_read_c = jittered(no2, jit);
		return s;
	endfunction

	// same three reads on every channel, rotated
	function automatic sample_t triple_round(input logic [READ_W-1:0] a,
			input logic [READ_W-1:0] b, input logic [READ_W-1:0] c);
		sample_t s;
		s.action     = ACT_SAMPLE;
		s.nh3_read_a = a;
		s.nh3_read_b = b;
		s.nh3_read_c = c;
		s.co_read_a  = b;
		s.co_read_b  = c;
		s.co_read_c  = a;
		s.no2_read_a = c;
		s.no2_read_b = a;
		s.no2_read_c = b;
		return s;
	endfunction

	function automatic sample_t noise_round(input logic act);
		sample_t s;
		s.action     = act;
		s.nh3_read_a = READ_W'($urandom);
		s.nh3_read_b = READ_W'($urandom);
		s.nh3_read_c = READ_W'($urandom);
		s.co_read_a  = READ_W'($urandom);
		s.co_read_b  = READ_W'($urandom);
		s.co_read_c  = READ_W'($urandom);
		s.no2_read_a = READ_W'($urandom);
		s.no2_read_b = READ_W'($urandom);
		s.no2_read_c = READ_W'($urandom);
		return s;
	endfunction

	// offer one item, returns at the edge that accepts it
	task automatic push_sample(input sample_t s);
		int gap;
		gap = 0;
		while (!calm && $urandom_range(99) < 8) gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		items_sent++;
		if (s.action == ACT_RESTART) restarts_sent++;
		calm <= (items_sent >= 600 && items_sent < 900);
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
	endtask

	// stop offering and wait until every owed result has come back
	task automatic quiesce();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic [2:0] addr);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic new_settings(input logic [TOL_W-1:0] tol, input logic [ROUND_W-1:0] lim);
		quiesce();
		reg_write(TOL_ADDR, 32'(tol));
		reg_write(MAXR_ADDR, 32'(lim));
		reg_read(TOL_ADDR);
		reg_read(MAXR_ADDR);
		settings++;
	endtask

	initial begin
		logic [READ_W-1:0]  b0;
		logic [READ_W-1:0]  b1;
		logic [READ_W-1:0]  b2;
		logic [TOL_W-1:0]   tol_pick;
		logic [ROUND_W-1:0] lim_pick;
		int unsigned        jit;
		int                 span;
		int                 extra;
		int                 effective;
		int                 pick;

		arst_n        = 1'b0;
		sample_valid  = 1'b0;
		sample        = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		calm          = 1'b0;
		items_sent    = 0;
		restarts_sent = 0;
		settings      = 0;
		effective     = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the registers
		reg_read(TOL_ADDR);
		reg_read(MAXR_ADDR);

		// all-zero reads settle on the first round, the next sample is ignored
		push_sample(steady_round(12'd0, 12'd0, 12'd0, 0));
		push_sample(steady_round(12'd4095, 12'd4095, 12'd4095, 0));
		push_sample(noise_round(ACT_RESTART));

		// read extremes and truncating averages
		push_sample(steady_round(12'd4095, 12'd4095, 12'd4095, 0));
		push_sample(triple_round(12'd4095, 12'd0, 12'd0));
		push_sample(triple_round(12'd1, 12'd1, 12'd0));
		push_sample(triple_round(12'd2, 12'd2, 12'd1));
		push_sample(triple_round(12'd4095, 12'd4095, 12'd4094));

		// a full window of constant reads wraps the ring and settles
		repeat (10) push_sample(steady_round(12'd1000, 12'd2000, 12'd3000, 0));
		push_sample(noise_round(ACT_SAMPLE));
		push_sample(noise_round(ACT_RESTART));

		// limit reached on a stable round still counts as failed
		new_settings(12'd4095, 10'd1);
		push_sample(noise_round(ACT_SAMPLE));
		push_sample(noise_round(ACT_SAMPLE));
		push_sample(noise_round(ACT_RESTART));

		// zero round limit fails on the first sample round
		new_settings(12'd2, 10'd0);
		push_sample(noise_round(ACT_SAMPLE));
		push_sample(noise_round(ACT_RESTART));

		// zero tolerance never settles, runs out the largest limit
		new_settings(12'd0, 10'd1023);
		b0 = READ_W'($urandom);
		b1 = READ_W'($urandom);
		b2 = READ_W'($urandom);
		repeat (1025) push_sample(steady_round(b0, b1, b2, 3));
		push_sample(noise_round(ACT_RESTART));

		// random calibration sessions under changing settings
		while (effective < RANDOM_ITEMS) begin
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(9))
					0: tol_pick = 12'd0;
					1: tol_pick = 12'd4095;
					2: tol_pick = TOL_W'($urandom);
					default: tol_pick = TOL_W'($urandom_range(8, 1));
				endcase
				case ($urandom_range(9))
					0: lim_pick = 10'd1;
					1: lim_pick = 10'd1023;
					2: lim_pick = ROUND_W'($urandom_range(1023, 1));
					default: lim_pick = ROUND_W'($urandom_range(30, 5));
				endcase
				new_settings(tol_pick, lim_pick);
			end
			push_sample(noise_round(ACT_RESTART));
			b0 = READ_W'($urandom);
			b1 = READ_W'($urandom);
			b2 = READ_W'($urandom);
			case ($urandom_range(4))
				0: jit = 0;
				1: jit = 1;
				2: jit = 2;
				3: jit = 4;
				default: jit = 40;
			endcase
			span  = $urandom_range(40, 6);
			extra = 0;
			for (int k = 0; k < span && extra < 3; k++) begin
				if (calibrated) extra++;
				else effective++;
				pick = $urandom_range(99);
				if (pick < 5) push_sample(noise_round(ACT_SAMPLE));
				else if (pick < 8) push_sample(noise_round(ACT_RESTART));
				else push_sample(steady_round(b0, b1, b2, jit));
			end
		end

		// drain and let the pipeline settle
		quiesce();
		repeat (8) @(posedge clk);

		$display("summary: %0d items sent (%0d restarts), %0d results checked",
			items_sent, restarts_sent, results_seen);
		$display("summary: %0d settled, %0d hit the round limit, %0d register settings",
			settled_count, limit_count, settings);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/gbsc_pkg.sv
rtl/gbsc_avg.sv
rtl/gbsc_chan.sv
rtl/gas_baseline_stability_calibrator.sv
sim/baseline_checker.sv
sim/tb_gas_baseline_stability_calibrator.sv
